// ===== design/srr_pkg.sv =====
package srr_pkg;

	// Default sizes of the receive window, the storage slots and the payload limit
	localparam int WINDOW_DEF      = 16;
	localparam int SLOTS_DEF       = 256;
	localparam int MAX_PAYLOAD_DEF = 1023;

	// Fixed field widths
	localparam int SEQ_W   = 8;
	localparam int LEN_W   = 10;
	localparam int KIND_W  = 2;
	localparam int SPAN_W  = 5;
	localparam int TIMER_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_SPAN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_CODE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIMEOUT = 2'd2;

	localparam logic [SPAN_W-1:0]  SPAN_RST    = 5'd16;
	localparam logic [SEQ_W-1:0]   CODE_RST    = 8'd255;
	localparam logic [TIMER_W-1:0] TIMEOUT_RST = 32'd1000;

	// Input commands
	localparam logic CMD_PACKET = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_RELEASE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACK       = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLOSE_ACK = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLOSED    = 2'd3;

	typedef struct packed {
		logic             command;
		logic [SEQ_W-1:0] seq_number;
		logic [LEN_W-1:0] payload_length;
	} srr_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SEQ_W-1:0]  slot_index;
		logic [LEN_W-1:0]  release_length;
		logic [SEQ_W-1:0]  ack_number;
		logic              last;
	} srr_result_t;

	typedef enum logic [1:0] {
		PH_RECV,
		PH_CLOSING,
		PH_CLOSED
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_READ,
		ST_CHECK
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic eval;
		logic release_entry;
		logic ack;
	} srr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic ev_emit;
		logic ev_release;
		logic rel_ok;
		logic out_free;
	} srr_status_t;

endpackage

// ===== design/srr_ctrl.sv =====
module srr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  srr_pkg::srr_status_t status,
	output srr_pkg::srr_cmd_t    cmd
);
	import srr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (status.ev_release) begin
					cmd.eval = 1'b1;
					state_d  = ST_READ;
				end else if (!status.ev_emit || status.out_free) begin
					cmd.eval = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_READ: begin
				// let the entry memory settle after the store
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.out_free) begin
					if (status.rel_ok) begin
						cmd.release_entry = 1'b1;
					end else begin
						cmd.ack = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_load_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_EVAL)
		else $error("accepted item did not enter evaluation");

	a_read_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |=> state_q == ST_CHECK)
		else $error("read cycle not followed by release check");

	a_ack_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ack |=> state_q == ST_IDLE)
		else $error("ack did not end the item");
`endif

endmodule

// ===== design/srr_dp.sv =====
module srr_dp #(
	parameter int WINDOW      = srr_pkg::WINDOW_DEF,
	parameter int SLOTS       = srr_pkg::SLOTS_DEF,
	parameter int MAX_PAYLOAD = srr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srr_pkg::srr_item_t            item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output srr_pkg::srr_result_t          result,
	input  logic                          cfg_valid,
	input  logic [srr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  srr_pkg::srr_cmd_t             cmd,
	output srr_pkg::srr_status_t          status
);
	import srr_pkg::*;

	localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SAT_W  = 17;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  len;
	} entry_t;

	// configuration
	logic [SPAN_W-1:0]  span_q;
	logic [SEQ_W-1:0]   code_q;
	logic [TIMER_W-1:0] timeout_q;

	// connection state
	srr_item_t          in_q;
	logic [WINDOW-1:0]  valid_q;
	entry_t             entry_mem_q [WINDOW];
	entry_t             rd_q;
	logic [IDX_W-1:0]   exp_q;
	logic [SLOT_W-1:0]  next_slot_q;
	phase_t             phase_q;
	logic [TIMER_W-1:0] timer_q;
	logic               out_valid_q;
	srr_result_t        out_q;

	logic               is_close;
	logic               in_window;
	logic [IDX_W-1:0]   seq_ix;
	logic [SEQ_W:0]     seq_dist;
	logic               store;
	logic               store_fire;
	logic [LEN_W-1:0]   sat_len;
	logic [TIMER_W-1:0] timer_inc;
	logic [IDX_W-1:0]   exp_inc;
	logic [IDX_W-1:0]   rd_addr;
	logic               ev_emit;
	logic               ev_release;
	srr_result_t        ev_result;
	phase_t             ev_phase;
	logic               ev_timer_clr;
	logic               ev_timer_inc;
	logic               out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q    <= SPAN_RST;
			code_q    <= CODE_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ACCEPT_SPAN:   span_q    <= cfg_data[SPAN_W-1:0];
				CFG_CLOSE_CODE:    code_q    <= cfg_data[SEQ_W-1:0];
				CFG_CLOSE_TIMEOUT: timeout_q <= cfg_data[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		seq_ix    = in_q.seq_number[IDX_W-1:0];
		is_close  = in_q.seq_number == code_q;
		in_window = {1'b0, in_q.seq_number} < (SEQ_W+1)'(WINDOW);
		// distance from the expected sequence, modulo the window
		if (seq_ix >= exp_q) begin
			seq_dist = (SEQ_W+1)'(seq_ix - exp_q);
		end else begin
			seq_dist = (SEQ_W+1)'(WINDOW) + (SEQ_W+1)'(seq_ix) - (SEQ_W+1)'(exp_q);
		end
		store = in_window && (seq_dist < (SEQ_W+1)'(span_q)) && !valid_q[seq_ix];
		if (SAT_W'(in_q.payload_length) > SAT_W'(MAX_PAYLOAD)) begin
			sat_len = LEN_W'(MAX_PAYLOAD);
		end else begin
			sat_len = in_q.payload_length;
		end
		timer_inc = timer_q + TIMER_W'(1);
		exp_inc   = (exp_q == IDX_W'(WINDOW - 1)) ? '0 : exp_q + IDX_W'(1);
	end

	always_comb begin
		ev_emit      = 1'b0;
		ev_release   = 1'b0;
		ev_phase     = phase_q;
		ev_timer_clr = 1'b0;
		ev_timer_inc = 1'b0;
		ev_result    = '0;
		ev_result.last = 1'b1;
		case (phase_q)
			PH_RECV: begin
				if (in_q.command == CMD_PACKET) begin
					if (is_close) begin
						ev_emit              = 1'b1;
						ev_phase             = PH_CLOSING;
						ev_timer_clr         = 1'b1;
						ev_result.kind       = KIND_CLOSE_ACK;
						ev_result.ack_number = code_q;
					end else begin
						ev_release = 1'b1;
					end
				end
			end
			PH_CLOSING: begin
				if (in_q.command == CMD_TICK) begin
					ev_timer_inc = 1'b1;
					if (timer_inc >= timeout_q) begin
						ev_emit        = 1'b1;
						ev_phase       = PH_CLOSED;
						ev_result.kind = KIND_CLOSED;
					end
				end else if (is_close) begin
					ev_emit              = 1'b1;
					ev_timer_clr         = 1'b1;
					ev_result.kind       = KIND_CLOSE_ACK;
					ev_result.ack_number = code_q;
				end
			end
			default: ;
		endcase
	end

	assign store_fire = cmd.eval && ev_release && store;
	assign out_free   = !out_valid_q || !result_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= item;
		end
	end

	// entry memory: one write port at the stored sequence, one read port at expected or next
	assign rd_addr = cmd.release_entry ? exp_inc : exp_q;

	always_ff @(posedge clk) begin
		if (store_fire) begin
			entry_mem_q[seq_ix] <= '{slot: next_slot_q, len: sat_len};
		end
		rd_q <= entry_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			exp_q       <= IDX_W'(1);
			next_slot_q <= '0;
			phase_q     <= PH_RECV;
			timer_q     <= '0;
		end else begin
			if (store_fire) begin
				valid_q[seq_ix] <= 1'b1;
				next_slot_q <= (next_slot_q == SLOT_W'(SLOTS - 1)) ? '0
					: next_slot_q + SLOT_W'(1);
			end
			if (cmd.release_entry) begin
				valid_q[exp_q] <= 1'b0;
				exp_q          <= exp_inc;
			end
			if (cmd.eval) begin
				phase_q <= ev_phase;
				if (ev_timer_clr) begin
					timer_q <= '0;
				end else if (ev_timer_inc) begin
					timer_q <= timer_inc;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.eval && ev_emit) || cmd.release_entry || cmd.ack) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval && ev_emit) begin
			out_q <= ev_result;
		end else if (cmd.release_entry) begin
			out_q <= '{kind: KIND_RELEASE, slot_index: SEQ_W'(rd_q.slot),
				release_length: rd_q.len, ack_number: '0, last: 1'b0};
		end else if (cmd.ack) begin
			out_q <= '{kind: KIND_ACK, slot_index: '0, release_length: '0,
				ack_number: SEQ_W'(exp_q), last: 1'b1};
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign status.ev_emit    = ev_emit;
	assign status.ev_release = ev_release;
	assign status.rel_ok     = valid_q[exp_q] && (rd_q.len != '0);
	assign status.out_free   = out_free;

`ifndef ASSERT_OFF
	a_closed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CLOSED |=> phase_q == PH_CLOSED)
		else $error("left the closed phase without reset");

	a_exp_moves_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.release_entry |=> $stable(exp_q))
		else $error("expected sequence moved without a release");

	a_slot_moves_on_store: assert property (@(posedge clk) disable iff (!arst_n)
		!store_fire |=> $stable(next_slot_q))
		else $error("slot counter moved without a store");

	a_release_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.release_entry |=> !valid_q[$past(exp_q)])
		else $error("released entry still marked valid");
`endif

endmodule

// ===== design/selective_repeat_receiver.sv =====
// Receive side of a selective-repeat link. Each item is either a packet header (sequence,
// payload length) or one time tick. An in-window packet is buffered in the window table with
// the next storage slot; then entries are released in order from the expected sequence,
// followed by a cumulative ack carrying the new expected sequence. The close code answers
// with a close ack and starts the closing phase; ticks then count toward the close timeout,
// after which the block reports the connection closed and ignores all further input until
// reset. A tick, a close packet or an ignored input ends after evaluation; a data packet
// goes through a read of the entry memory and a release loop over up to WINDOW entries,
// reading one entry per cycle through the registered read port while the output is free.
// Every result waits in an output register while result_stall is high. Configuration is
// written through cfg_valid/cfg_ready (always ready) and must only be changed while idle.
module selective_repeat_receiver #(
	parameter int WINDOW      = srr_pkg::WINDOW_DEF,
	parameter int SLOTS       = srr_pkg::SLOTS_DEF,
	parameter int MAX_PAYLOAD = srr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  srr_pkg::srr_item_t            item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output srr_pkg::srr_result_t          result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [srr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import srr_pkg::*;

	srr_cmd_t    cmd;
	srr_status_t status;

	assign cfg_ready = 1'b1;

	srr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	srr_dp #(
		.WINDOW      (WINDOW),
		.SLOTS       (SLOTS),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status)
	);

endmodule
